// ===== design/mlcdf_pkg.sv =====
`default_nettype none
package mlcdf_pkg;

  // phase codes
  localparam logic [2:0] PH_HUNT       = 3'd0;
  localparam logic [2:0] PH_HEADER     = 3'd1;
  localparam logic [2:0] PH_PAYLOAD    = 3'd2;
  localparam logic [2:0] PH_CRC_FIRST  = 3'd3;
  localparam logic [2:0] PH_CRC_SECOND = 3'd4;

  // configuration register indexes
  localparam logic REG_MAGIC  = 1'b0;
  localparam logic REG_ENDIAN = 1'b1;

  // status codes
  localparam logic [1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [1:0] ST_GOOD     = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [15:0] MAGIC_RESET  = 16'hAA55;
  localparam logic        ENDIAN_RESET = 1'b1;

  localparam int unsigned WIN_BYTES = 8;

  typedef logic [8*WIN_BYTES-1:0] window_t;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // join two bytes in arrival order into a 16-bit field
  function automatic logic [15:0] pair16(input logic be, input logic [7:0] first,
                                         input logic [7:0] second);
    return be ? {first, second} : {second, first};
  endfunction

endpackage
`default_nettype wire

// ===== design/magic_length_crc16_deframer_core.sv =====
`default_nettype none
// Byte-stream deframer: hunts for the 16-bit magic word, reads a 4-byte length and a
// 2-byte type, streams each payload byte out with the frame type and closes the frame
// with one status request carrying the computed and received CRC-16-CCITT. One byte is
// taken every clock cycle: all work for a byte is a single combinational pass from the
// state registers into the state and the result register, so a request appears on the
// cycle after its byte is taken. The only stall comes from the result register: while it
// holds a request that has not been taken, rx_ready drops, whether or not the next byte
// would yield a request. A bad length (below 4 or above MAX_FRAME_LEN) rescans the six
// header bytes after the magic, this byte included, for the magic in the same cycle.
// No clearing pass is needed after reset. Configuration is written through cfg_we,
// cfg_index (0 magic word, 1 byte order) and cfg_data.
module magic_length_crc16_deframer_core #(
  parameter int unsigned MAX_FRAME_LEN = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,

  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,

  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [7:0]       out_byte,
  output logic [15:0]      frame_type,
  output logic [1:0]       status,
  output logic             end_of_frame,
  output logic [15:0]      computed_crc,
  output logic [15:0]      received_crc
);

  logic [15:0] magic_word;
  logic        big_endian;

  logic [2:0]              phase, phase_next;
  mlcdf_pkg::window_t      held, held_next;
  logic [3:0]              held_count, held_count_next;
  logic [15:0]             bytes_left, bytes_left_next;
  logic [15:0]             current_type, current_type_next;
  logic [15:0]             running_crc, running_crc_next;
  logic [7:0]              first_crc_byte, first_crc_byte_next;

  logic        accept;
  logic        emit;
  logic [7:0]  r_byte;
  logic [1:0]  r_status;
  logic        r_end;
  logic [15:0] r_ccrc;
  logic [15:0] r_rcrc;

  mlcdf_pkg::window_t win;
  logic [15:0] len_hi, len_lo, rx_crc, bl_dec, hdr_type;
  logic [31:0] len;
  logic [4:0]  match;
  logic [2:0]  sel;
  logic [5:0]  shamt;

  assign rx_ready = !res_valid || res_ready;
  assign accept   = rx_valid && rx_ready;

  always_comb begin
    phase_next          = phase;
    held_next           = held;
    held_count_next     = held_count;
    bytes_left_next     = bytes_left;
    current_type_next   = current_type;
    running_crc_next    = running_crc;
    first_crc_byte_next = first_crc_byte;
    emit     = 1'b0;
    r_byte   = 8'h00;
    r_status = mlcdf_pkg::ST_PAYLOAD;
    r_end    = 1'b0;
    r_ccrc   = 16'h0000;
    r_rcrc   = 16'h0000;

    // header window as it stands once this byte is placed
    win = held;
    win[8*(mlcdf_pkg::WIN_BYTES-1) +: 8] = rx_byte;
    len_hi = mlcdf_pkg::pair16(big_endian, win[23:16], win[31:24]);
    len_lo = mlcdf_pkg::pair16(big_endian, win[39:32], win[47:40]);
    len    = big_endian ? {len_hi, len_lo} : {len_lo, len_hi};
    hdr_type = mlcdf_pkg::pair16(big_endian, win[55:48], win[63:56]);
    for (int i = 0; i < 5; i++) begin
      match[i] = (mlcdf_pkg::pair16(big_endian, win[8*(i+2) +: 8], win[8*(i+3) +: 8])
                  == magic_word);
    end
    sel = 3'd0;
    for (int i = 4; i >= 0; i--) begin
      if (match[i]) sel = 3'(i);
    end
    shamt = {sel + 3'd2, 3'b000};

    rx_crc = mlcdf_pkg::pair16(big_endian, first_crc_byte, rx_byte);
    bl_dec = bytes_left - 16'd1;

    case (phase)
      mlcdf_pkg::PH_PAYLOAD: begin
        running_crc_next = mlcdf_pkg::crc_byte(running_crc, rx_byte);
        emit   = 1'b1;
        r_byte = rx_byte;
        bytes_left_next = bl_dec;
        if (bl_dec == 16'd0) phase_next = mlcdf_pkg::PH_CRC_FIRST;
      end
      mlcdf_pkg::PH_CRC_FIRST: begin
        first_crc_byte_next = rx_byte;
        phase_next = mlcdf_pkg::PH_CRC_SECOND;
      end
      mlcdf_pkg::PH_CRC_SECOND: begin
        emit     = 1'b1;
        r_status = (rx_crc == running_crc) ? mlcdf_pkg::ST_GOOD : mlcdf_pkg::ST_MISMATCH;
        r_end    = 1'b1;
        r_ccrc   = running_crc;
        r_rcrc   = rx_crc;
        phase_next      = mlcdf_pkg::PH_HUNT;
        held_count_next = 4'd0;
      end
      mlcdf_pkg::PH_HUNT: begin
        if (held_count == 4'd1 &&
            mlcdf_pkg::pair16(big_endian, held[7:0], rx_byte) == magic_word) begin
          held_next[15:8] = rx_byte;
          held_count_next = 4'd2;
          phase_next      = mlcdf_pkg::PH_HEADER;
        end else begin
          held_next[7:0]  = rx_byte;
          held_count_next = 4'd1;
        end
      end
      mlcdf_pkg::PH_HEADER: begin
        if (held_count == 4'd7) begin
          if (len < 32'd4 || len > 32'(MAX_FRAME_LEN)) begin
            // drop the magic and search the rest of the window again
            if (match != 5'd0) begin
              held_next       = win >> shamt;
              held_count_next = 4'd6 - {1'b0, sel};
              phase_next      = mlcdf_pkg::PH_HEADER;
            end else begin
              held_next[7:0]  = rx_byte;
              held_count_next = 4'd1;
              phase_next      = mlcdf_pkg::PH_HUNT;
            end
          end else begin
            current_type_next = hdr_type;
            running_crc_next  = mlcdf_pkg::crc_byte(
                                  mlcdf_pkg::crc_byte(mlcdf_pkg::CRC_INIT, hdr_type[7:0]),
                                  hdr_type[15:8]);
            bytes_left_next   = len[15:0] - 16'd4;
            held_count_next   = 4'd0;
            phase_next = (len[15:0] == 16'd4) ? mlcdf_pkg::PH_CRC_FIRST
                                              : mlcdf_pkg::PH_PAYLOAD;
          end
        end else if (held_count < 4'd8) begin
          held_next[8*held_count[2:0] +: 8] = rx_byte;
          held_count_next = held_count + 4'd1;
        end
      end
      default: begin
        phase_next      = mlcdf_pkg::PH_HUNT;
        held_next[7:0]  = rx_byte;
        held_count_next = 4'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word     <= mlcdf_pkg::MAGIC_RESET;
      big_endian     <= mlcdf_pkg::ENDIAN_RESET;
      phase          <= mlcdf_pkg::PH_HUNT;
      held           <= '0;
      held_count     <= 4'd0;
      bytes_left     <= 16'd0;
      current_type   <= 16'd0;
      running_crc    <= mlcdf_pkg::CRC_INIT;
      first_crc_byte <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mlcdf_pkg::REG_MAGIC:  magic_word <= cfg_data;
          mlcdf_pkg::REG_ENDIAN: big_endian <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        phase          <= phase_next;
        held           <= held_next;
        held_count     <= held_count_next;
        bytes_left     <= bytes_left_next;
        current_type   <= current_type_next;
        running_crc    <= running_crc_next;
        first_crc_byte <= first_crc_byte_next;
      end
    end
  end

  // result register: load a new request, or drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte     <= r_byte;
      frame_type   <= current_type;
      status       <= r_status;
      end_of_frame <= r_end;
      computed_crc <= r_ccrc;
      received_crc <= r_rcrc;
    end
  end

endmodule
`default_nettype wire
